/* sv/apd_pkg.sv */
// Package for the pane splitter: status codes, register indexes and the
// records that travel down the divider chain and into the output buffer.
// No dependencies.
package apd_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  localparam logic [2:0] REG_BOUNDS_X      = 3'd0;
  localparam logic [2:0] REG_BOUNDS_Y      = 3'd1;
  localparam logic [2:0] REG_BOUNDS_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BOUNDS_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SPLIT_AXIS    = 3'd4;
  localparam logic [2:0] REG_PANE_COUNT    = 3'd5;
  localparam logic [2:0] REG_PANE_GAP      = 3'd6;

  localparam int unsigned NUM_BITS = 31;
  localparam int unsigned CNT_BITS = 16;

  // One query in flight through the divider cells.
  typedef struct packed {
    logic [CNT_BITS-1:0] idx;
    logic [31:0]         ig;    // index times gap
    logic [NUM_BITS-1:0] num;   // dividend bits not yet consumed
    logic [CNT_BITS-1:0] rem;   // partial remainder
    logic [NUM_BITS-1:0] quo;   // quotient bits so far
    status_e             st;
  } div_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        w;
    logic [30:0]        h;
    status_e            st;
  } res_t;

endpackage

/* sv/apd_if.sv */
// Stream interfaces for pane queries and pane results.
// No dependencies; the status field is a plain two-bit vector.
interface apd_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] pane_index;
  modport source (output valid, output pane_index, input ready);
  modport sink (input valid, input pane_index, output ready);
endinterface

interface apd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pane_x;
  logic signed [31:0] pane_y;
  logic [30:0]        pane_width;
  logic [30:0]        pane_height;
  logic [1:0]         status;
  modport source (output valid, output pane_x, output pane_y, output pane_width,
                  output pane_height, output status, input ready);
  modport sink (input valid, input pane_x, input pane_y, input pane_width,
                input pane_height, input status, output ready);
endinterface

/* sv/apd_div_cell.sv */
// One cell of the restoring divider chain: retires one quotient bit per cycle while en_i is high.
// Depends on apd_pkg.
module apd_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [15:0]   divisor_i,
  input  logic          valid_i,
  input  apd_pkg::div_t d_i,
  output logic          valid_o,
  output apd_pkg::div_t d_o
);
  import apd_pkg::*;

  logic [CNT_BITS:0] trial;
  logic [CNT_BITS:0] diff;
  logic              ge;
  div_t              nxt_d;
  logic              valid_q;
  div_t              d_q;

  always_comb begin
    trial = {d_i.rem, d_i.num[NUM_BITS-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
    nxt_d = d_i;
    nxt_d.num = {d_i.num[NUM_BITS-2:0], 1'b0};
    nxt_d.rem = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    nxt_d.quo = {d_i.quo[NUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= nxt_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

/* sv/axis_pane_split_core.sv */
// Pane splitter top level: config registers, pipeline and output buffer.
// Depends on apd_pkg, apd_if and apd_div_cell.
//
// Splits the configured rectangle along one axis into pane_count panes with
// pane_gap units between them; the leading (extent mod count) panes get one
// extra unit. One query is taken every cycle while the output buffer has room,
// and each result passes through two setup stages (gap product, gap check and
// subtract), 31 divider cells that each retire one quotient bit, two stages
// for the offset, and the output buffer. A two-entry output buffer keeps the
// query side open while one result waits. Write the registers only while no
// query is in flight.
module axis_pane_split_core #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  apd_req_if.sink     req,
  apd_rsp_if.source   rsp
);
  import apd_pkg::*;

  localparam int CB = (COUNT_BITS >= 16) ? 16 : COUNT_BITS;
  localparam logic [15:0] CMASK = 16'((32'd1 << CB) - 32'd1);
  localparam logic signed [33:0] CMAX = 34'((64'd1 << (COORD_BITS - 1)) - 64'd1);

  // configuration
  logic signed [31:0] bx_q, by_q;
  logic [30:0]        bw_q, bh_q, gap_q;
  logic               axis_q;
  logic [15:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bx_q   <= '0;
      by_q   <= '0;
      bw_q   <= '0;
      bh_q   <= '0;
      axis_q <= 1'b0;
      cnt_q  <= 16'd1;
      gap_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOUNDS_X:      bx_q   <= cfg_data_i;
        REG_BOUNDS_Y:      by_q   <= cfg_data_i;
        REG_BOUNDS_WIDTH:  bw_q   <= cfg_data_i[30:0];
        REG_BOUNDS_HEIGHT: bh_q   <= cfg_data_i[30:0];
        REG_SPLIT_AXIS:    axis_q <= cfg_data_i[0];
        REG_PANE_COUNT:    cnt_q  <= cfg_data_i[15:0];
        REG_PANE_GAP:      gap_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic [15:0] cnt;
  logic [30:0] limit;
  assign cnt   = cnt_q & CMASK;
  assign limit = axis_q ? bh_q : bw_q;

  // output buffer occupancy gates the whole pipeline
  logic [1:0] ob_cnt_q, ob_cnt_d;
  logic       en;
  assign en        = (ob_cnt_q != 2'd2);
  assign req.ready = en;

  // stage 0: gap products and range checks
  logic        v0_q;
  logic [15:0] idx0_q;
  logic [46:0] mcg0_q, mig0_q;
  status_e     st0_q;
  logic [15:0] idx_in;
  status_e     st_in;

  always_comb begin
    idx_in = req.pane_index & CMASK;
    if (cnt == 16'd0) begin
      st_in = ST_INVALID;
    end else if (idx_in >= cnt) begin
      st_in = ST_LIMIT;
    end else begin
      st_in = ST_OK;
    end
  end

  // stage 1: gap check and available extent
  logic  v1_q;
  div_t  d1_q;
  div_t  d1_d;

  always_comb begin
    d1_d     = '0;
    d1_d.idx = idx0_q;
    d1_d.ig  = mig0_q[31:0];
    d1_d.num = limit - mcg0_q[30:0];
    d1_d.st  = st0_q;
    if (st0_q == ST_OK && mcg0_q > 47'(limit)) begin
      d1_d.st = ST_LIMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= req.valid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx0_q <= idx_in;
      mcg0_q <= 47'(cnt - 16'd1) * 47'(gap_q);
      mig0_q <= 47'(idx_in) * 47'(gap_q);
      st0_q  <= st_in;
      d1_q   <= d1_d;
    end
  end

  // divider chain
  logic [NUM_BITS:0] cv;
  div_t              cd [NUM_BITS+1];
  assign cv[0] = v1_q;
  assign cd[0] = d1_q;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
    apd_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (cnt),
      .valid_i   (cv[k]),
      .d_i       (cd[k]),
      .valid_o   (cv[k+1]),
      .d_o       (cd[k+1])
    );
  end

  div_t dq;
  assign dq = cd[NUM_BITS];

  // stage 2: index times base, remainder share
  logic        v2_q;
  logic [31:0] ib2_q, ig2_q;
  logic [15:0] ex2_q;
  logic        p2_q;
  logic [30:0] base2_q;
  status_e     st2_q;
  logic        lt;
  assign lt = dq.idx < dq.rem;

  // stage 3: offset and extent
  logic        v3_q;
  logic [31:0] off3_q;
  logic [30:0] ext3_q;
  status_e     st3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= cv[NUM_BITS];
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ib2_q   <= 32'(47'(dq.idx) * 47'(dq.quo));
      ig2_q   <= dq.ig;
      ex2_q   <= lt ? dq.idx : dq.rem;
      p2_q    <= lt;
      base2_q <= dq.quo;
      st2_q   <= dq.st;
      off3_q  <= ib2_q + 32'(ex2_q) + ig2_q;
      ext3_q  <= base2_q + 31'(p2_q);
      st3_q   <= st2_q;
    end
  end

  // final: position, overflow check, result record
  logic signed [33:0] pos;
  res_t               res;

  always_comb begin
    pos    = (axis_q ? 34'(by_q) : 34'(bx_q)) + $signed({2'b00, off3_q});
    res    = '0;
    res.st = st3_q;
    if (st3_q == ST_OK && pos > CMAX) begin
      res.st = ST_OVERFLOW;
    end
    if (res.st == ST_OK) begin
      res.x = axis_q ? bx_q : pos[31:0];
      res.y = axis_q ? pos[31:0] : by_q;
      res.w = axis_q ? bw_q : ext3_q;
      res.h = axis_q ? ext3_q : bh_q;
    end
  end

  // two-entry output buffer
  res_t e0_q, e1_q, e0_d, e1_d;
  logic push, pop;
  assign push = en && v3_q;
  assign pop  = rsp.valid && rsp.ready;

  always_comb begin
    e0_d     = e0_q;
    e1_d     = e1_q;
    ob_cnt_d = ob_cnt_q;
    if (push && !pop) begin
      if (ob_cnt_q == 2'd0) begin
        e0_d = res;
      end else begin
        e1_d = res;
      end
      ob_cnt_d = ob_cnt_q + 2'd1;
    end else if (pop && !push) begin
      e0_d     = e1_q;
      ob_cnt_d = ob_cnt_q - 2'd1;
    end else if (pop && push) begin
      if (ob_cnt_q == 2'd1) begin
        e0_d = res;
      end else begin
        e0_d = e1_q;
        e1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else begin
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign rsp.valid       = (ob_cnt_q != 2'd0);
  assign rsp.pane_x      = e0_q.x;
  assign rsp.pane_y      = e0_q.y;
  assign rsp.pane_width  = e0_q.w;
  assign rsp.pane_height = e0_q.h;
  assign rsp.status      = e0_q.st;

endmodule

/* bench/tb_axis_pane_split_core.sv */
// Testbench for axis_pane_split_core: drives pane queries and register writes,
// predicts each pane rectangle and status, and checks every result in order.
// Depends on apd_pkg, apd_if and the RTL of axis_pane_split_core.
`timescale 1ns / 100ps

class pane_scoreboard;
  apd_pkg::res_t pending_q[$];
  int mismatches;

  function void note_query(apd_pkg::res_t r);
    pending_q.push_back(r);
  endfunction

  function void check_pane(apd_pkg::res_t got);
    apd_pkg::res_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pane result x=%0d y=%0d w=%0d h=%0d st=%0d",
                 got.x, got.y, got.w, got.h, got.st);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pane mismatch: exp x=%0d y=%0d w=%0d h=%0d st=%0d,",
                 want.x, want.y, want.w, want.h, want.st,
                 " got x=%0d y=%0d w=%0d h=%0d st=%0d",
                 got.x, got.y, got.w, got.h, got.st);
    end
  endfunction
endclass

module tb_axis_pane_split_core;
  import apd_pkg::*;

  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  apd_req_if req ();
  apd_rsp_if rsp ();

  // shadow copy of the registers
  logic signed [31:0] sh_x, sh_y;
  logic [30:0] sh_w, sh_h, sh_gap;
  logic        sh_axis;
  logic [15:0] sh_count;

  pane_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;
  int idle_cycles;
  int n_sent;

  axis_pane_split_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.pane_index = '0;
    rsp.ready = 1'b0;
  end

  function automatic res_t predict_pane(logic [15:0] idx);
    res_t r;
    longint unsigned cnt, lim, gap, avail, base, rem, extra, offset, extent;
    longint pos;
    r = '0;
    cnt = sh_count;
    gap = sh_gap;
    lim = sh_axis ? sh_h : sh_w;
    if (cnt == 0) begin
      r.st = ST_INVALID;
      return r;
    end
    if (idx >= cnt || (gap > 0 && cnt - 1 > lim / gap)) begin
      r.st = ST_LIMIT;
      return r;
    end
    avail = lim - (cnt - 1) * gap;
    base = avail / cnt;
    rem = avail % cnt;
    extra = (idx < rem) ? idx : rem;
    offset = idx * base + extra + idx * gap;
    extent = base + ((idx < rem) ? 1 : 0);
    pos = (sh_axis ? longint'(sh_y) : longint'(sh_x)) + longint'(offset);
    if (pos > 64'sh7FFF_FFFF) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.x = sh_axis ? sh_x : pos[31:0];
    r.y = sh_axis ? pos[31:0] : sh_y;
    r.w = sh_axis ? sh_w : extent[30:0];
    r.h = sh_axis ? extent[30:0] : sh_h;
    r.st = ST_OK;
    return r;
  endfunction

  // Drop the write enable after each write, before the next write can start.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BOUNDS_X:      sh_x = data;
      REG_BOUNDS_Y:      sh_y = data;
      REG_BOUNDS_WIDTH:  sh_w = data[30:0];
      REG_BOUNDS_HEIGHT: sh_h = data[30:0];
      REG_SPLIT_AXIS:    sh_axis = data[0];
      REG_PANE_COUNT:    sh_count = data[15:0];
      REG_PANE_GAP:      sh_gap = data[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic setup(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h,
                       logic [31:0] axis, logic [31:0] cnt, logic [31:0] gap);
    write_reg(REG_BOUNDS_X, x);
    write_reg(REG_BOUNDS_Y, y);
    write_reg(REG_BOUNDS_WIDTH, w);
    write_reg(REG_BOUNDS_HEIGHT, h);
    write_reg(REG_SPLIT_AXIS, axis);
    write_reg(REG_PANE_COUNT, cnt);
    write_reg(REG_PANE_GAP, gap);
  endtask

  // Hold until every expected pane has come back, then let the pipe drain.
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Valid stays high after a transfer so back-to-back queries need no gap.
  task automatic send_query(logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.pane_index <= idx;
    do @(posedge clk_i); while (!req.ready);
    sb.note_query(predict_pane(idx));
    n_sent++;
  endtask

  function automatic logic [15:0] pick_index();
    int unsigned k;
    k = $urandom_range(9);
    if (sh_count == 0 || k == 0) return 16'($urandom);
    if (k == 1) return sh_count;
    if (k == 2) return 16'(sh_count - 16'd1);
    return 16'($urandom_range(sh_count - 1));
  endfunction

  task automatic random_config();
    logic [31:0] w, h, gap, cnt, x, y;
    int unsigned k;
    k = $urandom_range(9);
    cnt = (k == 0) ? 32'($urandom) : (k == 1) ? 32'hFFFF : (k == 2) ? 0
          : $urandom_range(1, 40);
    w = (k == 3) ? 32'h7FFF_FFFF : ($urandom_range(1) ? $urandom_range(2000) : $urandom);
    h = (k == 4) ? 32'h7FFF_FFFF : ($urandom_range(1) ? $urandom_range(2000) : $urandom);
    gap = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(20));
    x = ($urandom_range(3) == 0) ? 32'h7FFF_FF00 + $urandom_range(255) : $urandom;
    y = ($urandom_range(3) == 0) ? 32'h8000_0000 + $urandom_range(255) : $urandom;
    setup(x, y, w, h, $urandom, cnt, gap);
  endtask

  // Receiver: random stall, plus a long hold when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready)
        sb.check_pane('{rsp.pane_x, rsp.pane_y, rsp.pane_width, rsp.pane_height,
                        status_e'(rsp.status)});
      rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_axis_pane_split_core failed");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_sent = 0;
    sh_x = 0; sh_y = 0; sh_w = 0; sh_h = 0; sh_axis = 0; sh_count = 1; sh_gap = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: one pane over an empty rectangle
    send_query(0);
    send_query(1);
    drain();
    // zero pane count
    setup(10, 20, 100, 50, 0, 0, 3);
    send_query(0);
    send_query(16'hFFFF);
    drain();
    // uneven split with remainder, row then column
    setup(-5, 7, 103, 61, 0, 4, 2);
    for (int i = 0; i < 5; i++) send_query(16'(i));
    drain();
    write_reg(REG_SPLIT_AXIS, 1);
    for (int i = 0; i < 4; i++) send_query(16'(i));
    drain();
    // gaps exceed extent
    setup(0, 0, 10, 10, 0, 3, 6);
    send_query(0);
    drain();
    // overflow near the top of the coordinate range, max extents and count
    setup(32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF, 0);
    send_query(0);
    send_query(16'hFFFE);
    send_query(16'hFFFF);
    drain();
    setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2,
          32'h7FFF_FFFF);
    send_query(0);
    send_query(1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 10 : 0;
      for (int blk = 0; blk < 8; blk++) begin
        random_config();
        for (int i = 0; i < 20; i++) send_query(pick_index());
        drain();
      end
    end

    // receiver holds off while queries keep coming; the input must stall
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_query(pick_index());
    join
    drain();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("tb_axis_pane_split_core passed");
    else
      $display("tb_axis_pane_split_core failed");
    $finish;
  end
endmodule
